// ----- src/dhcp_frame_mac_anonymizer_defines.svh -----
// Assertion macros for the port-level checker of the frame anonymizer.
`ifndef DHCP_FRAME_MAC_ANONYMIZER_DEFINES_SVH
`define DHCP_FRAME_MAC_ANONYMIZER_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define DFMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("%m: sequence check failed");

// The condition must never be seen at a clock edge.
`define DFMA_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("%m: forbidden condition seen");

`endif

// ----- src/dfma_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfma_pkg
// Types, protocol constants and the hostname tag function of the anonymizer.
// ----------------------------------------------------------------------------
package dfma_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_PROCESS = 2'd1,
		CMD_READ    = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_RD_WAIT, ST_START, ST_GATH, ST_HASH, ST_LEARN_ID, ST_LEARN_SYN,
		ST_REP_CHK, ST_REP_WR, ST_ETH_SRC, ST_ETH_TYPE, ST_ETH_TYPE2, ST_ARP_TPA,
		ST_ARP_DONE, ST_IP_VER, ST_IP_PROTO, ST_UDP_HDR, ST_BOOT_HW, ST_BOOT_DONE,
		ST_COOKIE, ST_MAGIC, ST_OPT, ST_OPT_CODE, ST_OPT_LEN, ST_OPT_NEXT, ST_CID,
		ST_CID_DONE, ST_HN_START, ST_HN_WR, ST_PAY_END, ST_CK_PSEUDO, ST_CK_SUM,
		ST_CK_FOLD, ST_CK_WR_HI, ST_CK_WR_LO, ST_FINISH
	} state_t;

	localparam logic [63:0] FNV_OFFSET     = 64'hcbf29ce484222325;
	localparam logic [63:0] FNV_PRIME      = 64'h00000100000001b3;
	localparam int          FNV_PRIME_SHIFT = 40;

	localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [15:0] PORT_BOOTPS    = 16'd67;
	localparam logic [15:0] PORT_BOOTPC    = 16'd68;
	localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
	localparam logic [7:0]  HTYPE_ETH      = 8'd1;
	localparam logic [7:0]  HLEN_ETH       = 8'd6;
	localparam logic [7:0]  OPT_PAD        = 8'h00;
	localparam logic [7:0]  OPT_END        = 8'hff;
	localparam logic [7:0]  OPT_HOSTNAME   = 8'd12;
	localparam logic [7:0]  OPT_CLIENT_ID  = 8'd61;
	localparam logic [7:0]  LOCAL_ADMIN    = 8'h02;
	localparam logic [31:0] DHCP_MAGIC     = 32'h63825363;
	localparam logic [4:0]  TAG_LAST       = 5'd16;

	// Byte idx of the 17-character hostname tag: a fixed nine-byte prefix
	// followed by the low hash word as eight lowercase hex digits.
	function automatic logic [7:0] tag_byte(input logic [4:0] idx, input logic [31:0] low);
		logic [4:0] k;
		logic [3:0] nib;
		logic [7:0] res;
		k   = idx - 5'd9;
		nib = low[(5'd31 - {k[2:0], 2'b00}) -: 4];
		unique case (idx)
			5'd0:    res = 8'h6e;
			5'd1:    res = 8'h64;
			5'd2:    res = 8'h73;
			5'd3:    res = 8'h67;
			5'd4:    res = 8'h75;
			5'd5:    res = 8'h65;
			5'd6:    res = 8'h73;
			5'd7:    res = 8'h74;
			5'd8:    res = 8'h2d;
			default: res = (nib < 4'd10) ? (8'h30 + {4'b0, nib}) : (8'h57 + {4'b0, nib});
		endcase
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- src/dfma_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfma_ram
// Frame byte store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module dfma_ram #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// ----- src/dfma_fnv.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfma_fnv
// Shared FNV-1a-64 hash unit, one byte per step.
// ----------------------------------------------------------------------------
module dfma_fnv import dfma_pkg::*; (
	input  wire logic        clk,
	input  wire logic        init,
	input  wire logic        step,
	input  wire logic [7:0]  byte_in,
	output logic      [63:0] hash
);

	logic [63:0] h_q;
	logic [63:0] x;

	assign x = h_q ^ {56'b0, byte_in};

	// The prime is 2^40 plus a 9-bit term, so the product is a shift and a
	// narrow multiply.
	always_ff @(posedge clk) begin
		if (init) begin
			h_q <= FNV_OFFSET;
		end else if (step) begin
			h_q <= (x << FNV_PRIME_SHIFT) + (x * {55'b0, FNV_PRIME[8:0]});
		end
	end

	assign hash = h_q;

endmodule
`default_nettype wire

// ----- src/dhcp_frame_mac_anonymizer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Load, no-op: the result is registered in the cycle after the item; read: the
// byte is fetched in ST_RD_WAIT, then registered. Process: a sequencer walks the
// header fields through one read port; option 12 is read to hash it and again to
// rewrite it; checksumming reads each UDP byte. No new item is taken meanwhile.
// Reset clears the learned identity; the frame store keeps its contents.
// ----------------------------------------------------------------------------
// dhcp_frame_mac_anonymizer
// Buffers a frame and rewrites the learned MAC identity, hostnames and UDP checksum in place.
// ----------------------------------------------------------------------------
module dhcp_frame_mac_anonymizer import dfma_pkg::*; #(
	parameter int MAX_FRAME_BYTES = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [10:0] byte_index, [18:11] data_byte, [30:19] frame_length, [31] transmit_dir
	input  wire logic [31:0] s_axis_tdata,
	// [1:0] command
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] read_byte, [8] frame_changed, [9] identity_valid, [15:10] zero
	output logic      [15:0] m_axis_tdata
);

	localparam int AW = $clog2(MAX_FRAME_BYTES);
	localparam int PW = ((AW > 12) ? AW : 12) + 2;
	typedef logic [PW-1:0] pos_t;

	cmd_t       in_cmd;
	logic [10:0] in_index;
	logic [7:0]  in_data;
	logic [11:0] in_len;
	logic        in_tx;
	logic        in_fire;
	pos_t        idx_pos;
	pos_t        len_ext;
	pos_t        len_sat;
	logic        idx_ok;

	state_t state_q, state_d, ret_q, ret_d, rret_q, rret_d;
	pos_t   gpos_q, gpos_d, n_q, n_d, cnt_q, cnt_d, len_q, len_d;
	pos_t   udp_q, udp_d, ulen_q, ulen_d, bend_q, bend_d, p_q, p_d;
	logic [63:0] gath_q, gath_d;
	logic        tx_q, tx_d, changed_q, changed_d, payload_q, payload_d;
	logic        rep_hit_q, rep_hit_d, csnz_q, csnz_d, known_q, known_d;
	logic        rd_ok_q, rd_ok_d;
	logic [7:0]  code_q, code_d, olen_q, olen_d;
	logic [31:0] hlow_q, hlow_d, sum_q, sum_d;
	logic [4:0]  tix_q, tix_d;
	logic [47:0] id_q, id_d, syn_q, syn_d;
	logic        out_valid_q, out_valid_d, out_chg_q, out_chg_d, out_id_q, out_id_d;
	logic [7:0]  out_byte_q, out_byte_d;

	pos_t        rd_addr, wr_addr;
	logic        wr_en;
	logic [7:0]  wr_data, rd_data;
	logic        fnv_init, fnv_step;
	logic [63:0] fnv_hash;
	logic [7:0]  tag_now, syn_byte;
	logic [15:0] ck_raw, ck;

	// Field unpacking and index checks.
	assign in_cmd   = cmd_t'(s_axis_tuser);
	assign in_index = s_axis_tdata[10:0];
	assign in_data  = s_axis_tdata[18:11];
	assign in_len   = s_axis_tdata[30:19];
	assign in_tx    = s_axis_tdata[31];
	assign idx_pos  = PW'(in_index);
	assign idx_ok   = idx_pos < PW'(MAX_FRAME_BYTES);
	assign len_ext  = PW'(in_len);
	assign len_sat  = (len_ext > PW'(MAX_FRAME_BYTES)) ? PW'(MAX_FRAME_BYTES) : len_ext;

	assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_id_q, out_chg_q, out_byte_q};

	assign tag_now  = tag_byte(tix_q, hlow_q);
	assign syn_byte = syn_q[(6'd47 - {cnt_q[2:0], 3'b000}) -: 8];
	assign ck_raw   = ~sum_q[15:0];
	assign ck       = (ck_raw == 16'h0000) ? 16'hffff : ck_raw;

	dfma_ram #(
		.DEPTH (MAX_FRAME_BYTES),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr[AW-1:0]),
		.wr_data (wr_data),
		.rd_addr (rd_addr[AW-1:0]),
		.rd_data (rd_data)
	);

	dfma_fnv u_fnv (
		.clk     (clk),
		.init    (fnv_init),
		.step    (fnv_step),
		.byte_in (rd_data),
		.hash    (fnv_hash)
	);

	// Memory and hash unit controls.
	always_comb begin
		rd_addr  = gpos_q + cnt_q;
		wr_en    = 1'b0;
		wr_addr  = gpos_q + cnt_q;
		wr_data  = syn_byte;
		fnv_init = 1'b0;
		fnv_step = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = idx_pos;
				wr_addr = idx_pos;
				wr_data = in_data;
				wr_en   = in_fire && (in_cmd == CMD_LOAD) && idx_ok;
			end
			ST_HASH: begin
				fnv_init = (cnt_q == '0);
				fnv_step = (cnt_q != '0);
			end
			ST_REP_WR: begin
				wr_en = 1'b1;
			end
			ST_HN_WR: begin
				wr_addr = gpos_q + cnt_q - PW'(1);
				wr_data = tag_now;
				wr_en   = (cnt_q != '0) && (rd_data != tag_now);
			end
			ST_CK_WR_HI: begin
				wr_addr = udp_q + PW'(6);
				wr_data = ck[15:8];
				wr_en   = 1'b1;
			end
			ST_CK_WR_LO: begin
				wr_addr = udp_q + PW'(7);
				wr_data = ck[7:0];
				wr_en   = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer. ST_GATH collects bytes into a shift register and ST_REP_CHK /
	// ST_REP_WR form the address replacement step; ST_GATH returns through ret_q
	// and the replacement step through rret_q.
	always_comb begin
		logic [15:0] sp, dp, ul;
		logic [5:0]  ihl;
		pos_t        room, ulen_n, cookie, opt_end, j;
		sp = gath_q[63:48];
		dp = gath_q[47:32];
		ul = gath_q[31:16];
		ihl = {gath_q[3:0], 2'b00};
		room = len_q - udp_q;
		ulen_n = ({{PW{1'b0}}, ul} > {16'b0, room}) ? room : ul[PW-1:0];
		cookie = udp_q + PW'(244);
		opt_end = p_q + PW'(2) + PW'(gath_q[7:0]);
		j = cnt_q - PW'(1);

		state_d = state_q; ret_d = ret_q; rret_d = rret_q;
		gpos_d = gpos_q; n_d = n_q; cnt_d = cnt_q; len_d = len_q;
		udp_d = udp_q; ulen_d = ulen_q; bend_d = bend_q; p_d = p_q;
		gath_d = gath_q; tx_d = tx_q; changed_d = changed_q; payload_d = payload_q;
		rep_hit_d = rep_hit_q; csnz_d = csnz_q; known_d = known_q; rd_ok_d = rd_ok_q;
		code_d = code_q; olen_d = olen_q; hlow_d = hlow_q; sum_d = sum_q;
		tix_d = tix_q; id_d = id_q; syn_d = syn_q;
		out_valid_d = out_valid_q && !m_axis_tready;
		out_byte_d = out_byte_q; out_chg_d = out_chg_q; out_id_d = out_id_q;

		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					unique case (in_cmd)
						CMD_LOAD, CMD_NOP: begin
							out_valid_d = 1'b1;
							out_byte_d  = 8'd0;
							out_chg_d   = 1'b0;
							out_id_d    = known_q;
						end
						CMD_READ: begin
							rd_ok_d = idx_ok;
							state_d = ST_RD_WAIT;
						end
						CMD_PROCESS: begin
							len_d     = len_sat;
							tx_d      = in_tx;
							changed_d = 1'b0;
							payload_d = 1'b0;
							state_d   = ST_START;
						end
					endcase
				end
			end
			ST_RD_WAIT: begin
				out_valid_d = 1'b1;
				out_byte_d  = rd_ok_q ? rd_data : 8'd0;
				out_chg_d   = 1'b0;
				out_id_d    = known_q;
				state_d     = ST_IDLE;
			end
			ST_START: begin
				if (len_q < PW'(14)) begin
					state_d = ST_FINISH;
				end else if (tx_q && !known_q) begin
					gpos_d = PW'(6); n_d = PW'(6); cnt_d = '0;
					ret_d = ST_LEARN_ID; state_d = ST_GATH;
				end else begin
					gpos_d = PW'(0); n_d = PW'(6); cnt_d = '0;
					ret_d = ST_REP_CHK; rret_d = ST_ETH_SRC; state_d = ST_GATH;
				end
			end
			ST_GATH: begin
				if (cnt_q != '0) begin
					gath_d = {gath_q[55:0], rd_data};
				end
				if (cnt_q == n_q) begin
					state_d = ret_q;
				end else begin
					cnt_d = cnt_q + PW'(1);
				end
			end
			ST_HASH: begin
				if (cnt_q == n_q) begin
					state_d = ret_q;
				end else begin
					cnt_d = cnt_q + PW'(1);
				end
			end
			ST_LEARN_ID: begin
				id_d = gath_q[47:0];
				gpos_d = PW'(6); n_d = PW'(6); cnt_d = '0;
				ret_d = ST_LEARN_SYN; state_d = ST_HASH;
			end
			ST_LEARN_SYN: begin
				syn_d = {LOCAL_ADMIN, fnv_hash[7:0], fnv_hash[15:8], fnv_hash[23:16],
					fnv_hash[31:24], fnv_hash[39:32]};
				known_d = 1'b1;
				gpos_d = PW'(0); n_d = PW'(6); cnt_d = '0;
				ret_d = ST_REP_CHK; rret_d = ST_ETH_SRC; state_d = ST_GATH;
			end
			ST_REP_CHK: begin
				rep_hit_d = known_q && (gath_q[47:0] == id_q) && (gath_q[47:0] != syn_q);
				cnt_d = '0;
				if (known_q && (gath_q[47:0] == id_q) && (gath_q[47:0] != syn_q)) begin
					state_d = ST_REP_WR;
				end else begin
					state_d = rret_q;
				end
			end
			ST_REP_WR: begin
				if (cnt_q == PW'(5)) begin
					state_d = rret_q;
				end else begin
					cnt_d = cnt_q + PW'(1);
				end
			end
			ST_ETH_SRC: begin
				changed_d = changed_q | rep_hit_q;
				gpos_d = PW'(6); n_d = PW'(6); cnt_d = '0;
				ret_d = ST_REP_CHK; rret_d = ST_ETH_TYPE; state_d = ST_GATH;
			end
			ST_ETH_TYPE: begin
				changed_d = changed_q | rep_hit_q;
				gpos_d = PW'(12); n_d = PW'(2); cnt_d = '0;
				ret_d = ST_ETH_TYPE2; state_d = ST_GATH;
			end
			ST_ETH_TYPE2: begin
				if (gath_q[15:0] == ETHERTYPE_ARP) begin
					if (len_q >= PW'(42)) begin
						gpos_d = PW'(22); n_d = PW'(6); cnt_d = '0;
						ret_d = ST_REP_CHK; rret_d = ST_ARP_TPA; state_d = ST_GATH;
					end else begin
						state_d = ST_FINISH;
					end
				end else if (gath_q[15:0] != ETHERTYPE_IPV4 || len_q < PW'(34)) begin
					state_d = ST_FINISH;
				end else begin
					gpos_d = PW'(14); n_d = PW'(1); cnt_d = '0;
					ret_d = ST_IP_VER; state_d = ST_GATH;
				end
			end
			ST_ARP_TPA: begin
				changed_d = changed_q | rep_hit_q;
				gpos_d = PW'(32); n_d = PW'(6); cnt_d = '0;
				ret_d = ST_REP_CHK; rret_d = ST_ARP_DONE; state_d = ST_GATH;
			end
			ST_ARP_DONE: begin
				changed_d = changed_q | rep_hit_q;
				state_d = ST_FINISH;
			end
			ST_IP_VER: begin
				udp_d = PW'(14) + PW'(ihl);
				if (gath_q[7:4] != 4'd4 || ihl < 6'd20 || PW'(14) + PW'(ihl) > len_q) begin
					state_d = ST_FINISH;
				end else begin
					gpos_d = PW'(23); n_d = PW'(1); cnt_d = '0;
					ret_d = ST_IP_PROTO; state_d = ST_GATH;
				end
			end
			ST_IP_PROTO: begin
				if (gath_q[7:0] != IP_PROTO_UDP || udp_q + PW'(8) > len_q) begin
					state_d = ST_FINISH;
				end else begin
					gpos_d = udp_q; n_d = PW'(8); cnt_d = '0;
					ret_d = ST_UDP_HDR; state_d = ST_GATH;
				end
			end
			ST_UDP_HDR: begin
				ulen_d = ulen_n;
				csnz_d = (gath_q[15:0] != 16'd0);
				bend_d = udp_q + ulen_n;
				if (!(sp == PORT_BOOTPS || sp == PORT_BOOTPC ||
						dp == PORT_BOOTPS || dp == PORT_BOOTPC) || ulen_n < PW'(8)) begin
					state_d = ST_FINISH;
				end else if (ulen_n >= PW'(42) && known_q) begin
					gpos_d = udp_q + PW'(9); n_d = PW'(2); cnt_d = '0;
					ret_d = ST_BOOT_HW; state_d = ST_GATH;
				end else begin
					state_d = ST_COOKIE;
				end
			end
			ST_BOOT_HW: begin
				if (gath_q[15:8] == HTYPE_ETH && gath_q[7:0] == HLEN_ETH) begin
					gpos_d = udp_q + PW'(36); n_d = PW'(6); cnt_d = '0;
					ret_d = ST_REP_CHK; rret_d = ST_BOOT_DONE; state_d = ST_GATH;
				end else begin
					state_d = ST_COOKIE;
				end
			end
			ST_BOOT_DONE: begin
				payload_d = payload_q | rep_hit_q;
				state_d = ST_COOKIE;
			end
			ST_COOKIE: begin
				if (cookie + PW'(4) <= bend_q) begin
					gpos_d = cookie; n_d = PW'(4); cnt_d = '0;
					ret_d = ST_MAGIC; state_d = ST_GATH;
				end else begin
					state_d = ST_PAY_END;
				end
			end
			ST_MAGIC: begin
				p_d = cookie + PW'(4);
				state_d = (gath_q[31:0] == DHCP_MAGIC) ? ST_OPT : ST_PAY_END;
			end
			ST_OPT: begin
				if (p_q >= bend_q) begin
					state_d = ST_PAY_END;
				end else begin
					gpos_d = p_q; n_d = PW'(1); cnt_d = '0;
					ret_d = ST_OPT_CODE; state_d = ST_GATH;
				end
			end
			ST_OPT_CODE: begin
				code_d = gath_q[7:0];
				if (gath_q[7:0] == OPT_END) begin
					state_d = ST_PAY_END;
				end else if (gath_q[7:0] == OPT_PAD) begin
					p_d = p_q + PW'(1);
					state_d = ST_OPT;
				end else if (p_q + PW'(1) >= bend_q) begin
					state_d = ST_PAY_END;
				end else begin
					gpos_d = p_q + PW'(1); n_d = PW'(1); cnt_d = '0;
					ret_d = ST_OPT_LEN; state_d = ST_GATH;
				end
			end
			ST_OPT_LEN: begin
				olen_d = gath_q[7:0];
				if (opt_end > bend_q) begin
					state_d = ST_PAY_END;
				end else if (known_q && code_q == OPT_CLIENT_ID && gath_q[7:0] == 8'd7) begin
					gpos_d = p_q + PW'(2); n_d = PW'(7); cnt_d = '0;
					ret_d = ST_CID; state_d = ST_GATH;
				end else if (code_q == OPT_HOSTNAME && gath_q[7:0] != 8'd0) begin
					gpos_d = p_q + PW'(2); n_d = PW'(gath_q[7:0]); cnt_d = '0;
					ret_d = ST_HN_START; state_d = ST_HASH;
				end else begin
					state_d = ST_OPT_NEXT;
				end
			end
			ST_OPT_NEXT: begin
				p_d = p_q + PW'(2) + PW'(olen_q);
				state_d = ST_OPT;
			end
			ST_CID: begin
				if (gath_q[55:48] == HTYPE_ETH && gath_q[47:0] == id_q) begin
					gpos_d = p_q + PW'(3); n_d = PW'(6); cnt_d = '0;
					ret_d = ST_REP_CHK; rret_d = ST_CID_DONE; state_d = ST_GATH;
				end else begin
					state_d = ST_OPT_NEXT;
				end
			end
			ST_CID_DONE: begin
				payload_d = payload_q | rep_hit_q;
				state_d = ST_OPT_NEXT;
			end
			ST_HN_START: begin
				hlow_d = fnv_hash[31:0];
				gpos_d = p_q + PW'(2); n_d = PW'(olen_q); cnt_d = '0;
				tix_d = 5'd0;
				state_d = ST_HN_WR;
			end
			ST_HN_WR: begin
				// The byte read last cycle is compared and rewritten while the
				// next one is fetched.
				if (cnt_q != '0) begin
					if (rd_data != tag_now) begin
						payload_d = 1'b1;
					end
					tix_d = (tix_q == TAG_LAST) ? 5'd0 : tix_q + 5'd1;
				end
				if (cnt_q == n_q) begin
					state_d = ST_OPT_NEXT;
				end else begin
					cnt_d = cnt_q + PW'(1);
				end
			end
			ST_PAY_END: begin
				if (payload_q && csnz_q) begin
					gpos_d = PW'(26); n_d = PW'(8); cnt_d = '0;
					ret_d = ST_CK_PSEUDO; state_d = ST_GATH;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_CK_PSEUDO: begin
				sum_d = {16'b0, gath_q[63:48]} + {16'b0, gath_q[47:32]} +
					{16'b0, gath_q[31:16]} + {16'b0, gath_q[15:0]} +
					32'd17 + 32'(ulen_q);
				gpos_d = udp_q; n_d = ulen_q; cnt_d = '0;
				state_d = ST_CK_SUM;
			end
			ST_CK_SUM: begin
				// Even offsets are the high byte of a word; the checksum field is skipped.
				if (cnt_q != '0 && j != PW'(6) && j != PW'(7)) begin
					sum_d = sum_q + (j[0] ? {24'b0, rd_data} : {16'b0, rd_data, 8'b0});
				end
				if (cnt_q == n_q) begin
					state_d = ST_CK_FOLD;
				end else begin
					cnt_d = cnt_q + PW'(1);
				end
			end
			ST_CK_FOLD: begin
				if (sum_q[31:16] != 16'd0) begin
					sum_d = {16'b0, sum_q[15:0]} + {16'b0, sum_q[31:16]};
				end else begin
					state_d = ST_CK_WR_HI;
				end
			end
			ST_CK_WR_HI: begin
				state_d = ST_CK_WR_LO;
			end
			ST_CK_WR_LO: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				out_valid_d = 1'b1;
				out_byte_d  = 8'd0;
				out_chg_d   = changed_q | payload_q;
				out_id_d    = known_q;
				state_d     = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			rret_q      <= ST_IDLE;
			known_q     <= 1'b0;
			id_q        <= '0;
			syn_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ret_q       <= ret_d;
			rret_q      <= rret_d;
			known_q     <= known_d;
			id_q        <= id_d;
			syn_q       <= syn_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		gpos_q     <= gpos_d;
		n_q        <= n_d;
		cnt_q      <= cnt_d;
		len_q      <= len_d;
		udp_q      <= udp_d;
		ulen_q     <= ulen_d;
		bend_q     <= bend_d;
		p_q        <= p_d;
		gath_q     <= gath_d;
		tx_q       <= tx_d;
		changed_q  <= changed_d;
		payload_q  <= payload_d;
		rep_hit_q  <= rep_hit_d;
		csnz_q     <= csnz_d;
		rd_ok_q    <= rd_ok_d;
		code_q     <= code_d;
		olen_q     <= olen_d;
		hlow_q     <= hlow_d;
		sum_q      <= sum_d;
		tix_q      <= tix_d;
		out_byte_q <= out_byte_d;
		out_chg_q  <= out_chg_d;
		out_id_q   <= out_id_d;
	end

endmodule
`default_nettype wire

// ----- src/dfma_check.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "dhcp_frame_mac_anonymizer_defines.svh"
// ----------------------------------------------------------------------------
// dfma_check
// Port-level checks of the anonymizer, bound to the top level.
// ----------------------------------------------------------------------------
module dfma_check import dfma_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [1:0]  s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata
);

	// A stalled result item stays put.
	`DFMA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// One item at a time: no new item is taken while a result waits.
	`DFMA_ASSERT_NEVER(a_one_at_a_time, clk, arst_n, s_axis_tready && m_axis_tvalid)

	// A load answers in the next cycle with no data and no change flag.
	`DFMA_ASSERT_NEXT(a_load_result, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_LOAD, m_axis_tvalid && m_axis_tdata[8:0] == 9'd0)

endmodule

bind dhcp_frame_mac_anonymizer dfma_check u_dfma_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ----- sim/dfma_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfma_checker
// Watches both streams of the frame anonymizer, keeps its own image of the
// frame store and the learned identity, predicts every result item and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module dfma_checker import dfma_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [31:0] s_tdata,
	input  wire logic [1:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,
	output int               errors,
	output int               waiting
);

	typedef struct packed {
		logic [7:0] rd;
		logic       chg;
		logic       idv;
	} outcome_t;

	outcome_t    pending[$];
	logic [7:0]  img [0:2047];
	logic [47:0] id_mac;
	logic [47:0] syn_mac;
	bit          id_known;

	initial begin
		errors  = 0;
		waiting = 0;
	end

	function automatic logic [63:0] fnv64(int unsigned pos, int unsigned n);
		logic [63:0] h;
		h = FNV_OFFSET;
		for (int unsigned i = 0; i < n; i++) begin
			h = h ^ {56'd0, img[pos + i]};
			h = h * FNV_PRIME;
		end
		return h;
	endfunction

	function automatic logic [15:0] word(int unsigned pos);
		return {img[pos], img[pos + 1]};
	endfunction

	function automatic bit mac_match(int unsigned pos, logic [47:0] a);
		for (int k = 0; k < 6; k++)
			if (img[pos + k] != a[8 * (5 - k) +: 8]) return 0;
		return 1;
	endfunction

	function automatic bit swap_in(int unsigned pos);
		if (!id_known || !mac_match(pos, id_mac)) return 0;
		if (mac_match(pos, syn_mac)) return 0;
		for (int k = 0; k < 6; k++) img[pos + k] = syn_mac[8 * (5 - k) +: 8];
		return 1;
	endfunction

	function automatic bit hide_name(int unsigned pos, int unsigned n);
		logic [7:0]  tag [17];
		logic [63:0] h;
		logic [31:0] low;
		logic [3:0]  nib;
		bit          diff;
		h    = fnv64(pos, n);
		low  = h[31:0];
		diff = 0;
		tag  = '{8'h6e, 8'h64, 8'h73, 8'h67, 8'h75, 8'h65, 8'h73, 8'h74, 8'h2d,
			8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0};
		for (int i = 0; i < 8; i++) begin
			nib = low[31 - 4 * i -: 4];
			tag[9 + i] = (nib < 4'd10) ? 8'h30 + nib : 8'h57 + nib;
		end
		for (int unsigned i = 0; i < n; i++)
			if (img[pos + i] != tag[i % 17]) begin
				img[pos + i] = tag[i % 17];
				diff = 1;
			end
		return diff;
	endfunction

	function automatic logic [15:0] udp_sum(int unsigned udp, int unsigned ulen);
		logic [31:0] s;
		int unsigned i;
		s = word(26) + word(28) + word(30) + word(32) + 32'd17 + ulen;
		for (i = 0; i + 1 < ulen; i += 2)
			if (i != 6) s = s + word(udp + i);
		if (i < ulen) s = s + {img[udp + i], 8'h00};
		while (s[31:16] != 0) s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
		s = ~s & 32'hffff;
		return (s == 0) ? 16'hffff : s[15:0];
	endfunction

	// Rewrites the frame in the image; returns whether any byte changed.
	function automatic bit scrub(int unsigned n, bit tx);
		bit          chg, pay;
		int unsigned ihl, udp, ulen, bootp, blen, ck, bend, p, code, olen;
		logic [63:0] h;
		logic [15:0] c, sp, dp;
		chg = 0;
		pay = 0;
		if (n < 14) return 0;
		if (tx && !id_known) begin
			h = fnv64(6, 6);
			for (int k = 0; k < 6; k++) id_mac = {id_mac[39:0], img[6 + k]};
			id_known = 1;
			syn_mac  = {LOCAL_ADMIN, h[7:0], h[15:8], h[23:16], h[31:24], h[39:32]};
		end
		if (swap_in(0)) chg = 1;
		if (swap_in(6)) chg = 1;
		if (word(12) == ETHERTYPE_ARP) begin
			if (n >= 42) begin
				if (swap_in(22)) chg = 1;
				if (swap_in(32)) chg = 1;
			end
			return chg;
		end
		if (word(12) != ETHERTYPE_IPV4 || n < 34) return chg;
		ihl = int'(img[14][3:0]) * 4;
		if (img[14][7:4] != 4'd4 || ihl < 20 || 14 + ihl > n) return chg;
		if (img[23] != IP_PROTO_UDP) return chg;
		udp = 14 + ihl;
		if (udp + 8 > n) return chg;
		sp = word(udp);
		dp = word(udp + 2);
		if (!(sp == PORT_BOOTPS || sp == PORT_BOOTPC || dp == PORT_BOOTPS ||
			dp == PORT_BOOTPC)) return chg;
		ulen = word(udp + 4);
		if (ulen > n - udp) ulen = n - udp;
		if (ulen < 8) return chg;
		bootp = udp + 8;
		blen  = ulen - 8;
		if (blen >= 34 && id_known && img[bootp + 1] == HTYPE_ETH &&
			img[bootp + 2] == HLEN_ETH)
			if (swap_in(bootp + 28)) pay = 1;
		ck   = bootp + 236;
		bend = bootp + blen;
		if (ck + 4 <= bend && {img[ck], img[ck + 1], img[ck + 2], img[ck + 3]} == DHCP_MAGIC) begin
			p = ck + 4;
			while (p < bend) begin
				code = img[p];
				if (code == OPT_END) break;
				if (code == OPT_PAD) begin
					p++;
					continue;
				end
				if (p + 1 >= bend) break;
				olen = img[p + 1];
				if (p + 2 + olen > bend) break;
				if (id_known && code == OPT_CLIENT_ID && olen == 7 && img[p + 2] == HTYPE_ETH &&
					mac_match(p + 3, id_mac)) begin
					if (swap_in(p + 3)) pay = 1;
				end else if (code == OPT_HOSTNAME && olen > 0) begin
					if (hide_name(p + 2, olen)) pay = 1;
				end
				p += 2 + olen;
			end
		end
		if (pay) begin
			chg = 1;
			if (word(udp + 6) != 0) begin
				c = udp_sum(udp, ulen);
				img[udp + 6] = c[15:8];
				img[udp + 7] = c[7:0];
			end
		end
		return chg;
	endfunction

	task automatic report(string what, int want, int got);
		$display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t    want;
		int unsigned n;
		if (!arst_n) begin
			id_known = 0;
			id_mac   = '0;
			syn_mac  = '0;
			pending.delete();
			waiting  = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending.size() == 0) begin
					report("unexpected result item", 0, m_tdata);
				end else begin
					want = pending.pop_front();
					if (m_tdata[7:0] != want.rd) report("read_byte", want.rd, m_tdata[7:0]);
					if (m_tdata[8] != want.chg) report("frame_changed", want.chg, m_tdata[8]);
					if (m_tdata[9] != want.idv) report("identity_valid", want.idv, m_tdata[9]);
					if (m_tdata[15:10] != 0) report("padding bits", 0, m_tdata[15:10]);
				end
			end
			if (s_tvalid && s_tready) begin
				want = '0;
				case (cmd_t'(s_tuser))
					CMD_LOAD: img[s_tdata[10:0]] = s_tdata[18:11];
					CMD_PROCESS: begin
						n = s_tdata[30:19];
						if (n > 2048) n = 2048;
						want.chg = scrub(n, s_tdata[31]);
					end
					CMD_READ: want.rd = img[s_tdata[10:0]];
					default: ;
				endcase
				want.idv = id_known;
				pending.push_back(want);
			end
			waiting = pending.size();
		end
	end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the frame anonymizer with crafted DHCP, ARP and other Ethernet frames,
// loaded byte by byte, processed and read back, under random stream back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
	import dfma_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int ITEMS = 550;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = CMD_NOP;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [15:0] m_axis_tdata;

	int errors, waiting, cycles, n_items, tx_idle, rx_idle;

	logic [7:0]  shadow [0:2047];
	bit          known  [0:2047];
	logic [7:0]  frm    [0:2047];
	logic [7:0]  body   [0:235];
	logic [47:0] my_mac;

	always #5 clk = ~clk;

	dhcp_frame_mac_anonymizer u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	dfma_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
		.s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
		.m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_tdata(m_axis_tdata),
		.errors(errors), .waiting(waiting)
	);

	always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= rx_idle);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send(cmd_t c, int idx, int d, int n, bit tx);
		// The first third of the items sees a slow receiver, the second a slow
		// sender, the last neither.
		tx_idle = (n_items < ITEMS / 3) ? 26 : (n_items < 2 * ITEMS / 3) ? 88 : 0;
		rx_idle = (n_items < ITEMS / 3) ? 88 : (n_items < 2 * ITEMS / 3) ? 26 : 0;
		while ($urandom_range(99) < tx_idle) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser  <= c;
		s_axis_tdata  <= {tx, 12'(n), 8'(d), 11'(idx)};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		n_items++;
	endtask

	// Loads a byte unless the store is known to hold it already.
	task automatic put(int i, logic [7:0] v);
		if (!known[i] || shadow[i] != v) begin
			send(CMD_LOAD, i, v, $urandom, $urandom);
			shadow[i] = v;
			known[i]  = 1;
		end
	endtask

	// Loads the first nl frame bytes and processes n bytes.
	// udp < 0: anything may have changed; udp == 0: only bytes below 38 may change.
	task automatic run_frame(int nl, int n, bit tx, int udp);
		int m, bootp, top;
		for (int i = 0; i < nl; i++) put(i, frm[i]);
		send(CMD_PROCESS, $urandom, $urandom, n, tx);
		m = (n > 2048) ? 2048 : n;
		top = (m < nl) ? m : nl;
		bootp = udp + 8;
		for (int i = 0; i < m; i++)
			if (udp < 0 || (udp == 0 && i < 38) ||
				(udp > 0 && !((i >= 38 && i < udp + 6) || (i >= bootp && i < bootp + 28) ||
				(i >= bootp + 34 && i < bootp + 240))))
				known[i] = 0;
		if (udp > 0) begin
			send(CMD_READ, udp + 6, $urandom, $urandom, $urandom);
			send(CMD_READ, udp + 7, $urandom, $urandom, $urandom);
		end
		repeat ($urandom_range(2, 5))
			send(CMD_READ, $urandom_range(0, (top > 0) ? top - 1 : 0), $urandom, $urandom,
				$urandom);
	endtask

	task automatic put_mac(int pos, logic [47:0] a);
		for (int k = 0; k < 6; k++) frm[pos + k] = a[8 * (5 - k) +: 8];
	endtask

	task automatic build_dhcp(bit clean, output int flen, output int udp, output int hpos);
		int ihl, hdr, p, bootp, hl, r, ulen;
		r = $urandom_range(9);
		put_mac(0, (r < 5) ? my_mac : (r < 7) ? 48'hffffffffffff : {$urandom, $urandom});
		put_mac(6, (clean || $urandom_range(9) < 8) ? my_mac : {$urandom, $urandom});
		frm[12] = 8'h08;
		frm[13] = (clean || $urandom_range(19) != 0) ? 8'h00 : 8'($urandom);
		ihl = (clean || $urandom_range(9) < 7) ? 5 : $urandom_range(3, 15);
		hdr = (ihl < 5) ? 20 : ihl * 4;
		for (int i = 15; i < 14 + hdr; i++) frm[i] = $urandom;
		frm[14] = {(clean || $urandom_range(19) != 0) ? 4'd4 : 4'($urandom), 4'(ihl)};
		frm[23] = (clean || $urandom_range(19) != 0) ? IP_PROTO_UDP : 8'd6;
		udp = 14 + hdr;
		r = clean ? 0 : $urandom_range(4);
		{frm[udp], frm[udp + 1], frm[udp + 2], frm[udp + 3]} =
			(r < 2) ? {PORT_BOOTPC, PORT_BOOTPS} : (r == 2) ? {PORT_BOOTPS, PORT_BOOTPC} :
			(r == 3) ? {16'($urandom), PORT_BOOTPC} : {16'd5353, 16'd53};
		bootp = udp + 8;
		for (int i = 0; i < 236; i++) frm[bootp + i] = body[i];
		frm[bootp + 1] = (clean || $urandom_range(9) != 0) ? HTYPE_ETH : 8'($urandom);
		frm[bootp + 2] = (clean || $urandom_range(9) != 0) ? HLEN_ETH : 8'($urandom);
		put_mac(bootp + 28, (clean || $urandom_range(4) != 0) ? my_mac : {$urandom, $urandom});
		{frm[bootp + 236], frm[bootp + 237], frm[bootp + 238], frm[bootp + 239]} =
			(clean || $urandom_range(14) != 0) ? DHCP_MAGIC : 32'($urandom);
		p = bootp + 240;
		frm[p] = 8'd53;
		frm[p + 1] = 8'd1;
		frm[p + 2] = $urandom_range(1, 8);
		p += 3;
		repeat ($urandom_range(0, 2)) frm[p++] = OPT_PAD;
		if (clean || $urandom_range(3) != 0) begin
			frm[p] = OPT_CLIENT_ID;
			frm[p + 1] = (clean || $urandom_range(7) != 0) ? 8'd7 : 8'd6;
			frm[p + 2] = (clean || $urandom_range(7) != 0) ? HTYPE_ETH : 8'd0;
			put_mac(p + 3, (clean || $urandom_range(5) != 0) ? my_mac : {$urandom, $urandom});
			p += 2 + frm[p + 1];
		end
		repeat ((clean || $urandom_range(4) != 0) ? 1 : 2) begin
			hl = clean ? $urandom_range(1, 40) : $urandom_range(0, 40);
			hpos = p + 2;
			frm[p] = OPT_HOSTNAME;
			frm[p + 1] = hl;
			for (int i = 0; i < hl; i++) frm[hpos + i] = 8'h61 + $urandom_range(25);
			p += 2 + hl;
		end
		if (!clean && $urandom_range(5) == 0) begin
			// Option claiming more bytes than the payload holds.
			frm[p] = 8'd50;
			frm[p + 1] = $urandom_range(5, 200);
			frm[p + 2] = $urandom;
			p += 3;
		end else begin
			frm[p++] = OPT_END;
		end
		ulen = p - udp;
		r = clean ? 0 : $urandom_range(9);
		if (r == 8) ulen = ulen + $urandom_range(1, 100);
		if (r == 9) ulen = $urandom_range(0, 7);
		{frm[udp + 4], frm[udp + 5]} = 16'(ulen);
		{frm[udp + 6], frm[udp + 7]} = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
		flen = p;
		repeat ($urandom_range(0, 3)) frm[flen++] = $urandom;
		if (!clean && $urandom_range(5) == 0) flen = $urandom_range(14, flen);
	endtask

	task automatic build_arp(output int flen);
		put_mac(0, $urandom_range(1) ? my_mac : 48'hffffffffffff);
		put_mac(6, $urandom_range(3) ? my_mac : {$urandom, $urandom});
		frm[12] = 8'h08;
		frm[13] = 8'h06;
		for (int i = 14; i < 22; i++) frm[i] = $urandom;
		put_mac(22, $urandom_range(3) ? my_mac : {$urandom, $urandom});
		for (int i = 28; i < 32; i++) frm[i] = $urandom;
		put_mac(32, $urandom_range(1) ? my_mac : {$urandom, $urandom});
		flen = $urandom_range(3) ? $urandom_range(42, 60) : $urandom_range(34, 41);
		for (int i = 38; i < flen; i++) frm[i] = $urandom;
	endtask

	task automatic build_misc(output int flen);
		put_mac(0, $urandom_range(1) ? my_mac : {$urandom, $urandom});
		put_mac(6, $urandom_range(1) ? my_mac : {$urandom, $urandom});
		frm[12] = 8'h86;
		frm[13] = 8'hdd;
		flen = $urandom_range(14, 60);
		for (int i = 14; i < flen; i++) frm[i] = $urandom;
	endtask

	// Makes the rewritten payload fold to all ones, so the recomputed checksum is zero and goes out as all ones.
	task automatic force_zero_sum(int udp, int hpos);
		logic [7:0]  pfx [9];
		logic [31:0] s;
		logic [15:0] x;
		int          ulen, bootp, i;
		pfx   = '{8'h6e, 8'h64, 8'h73, 8'h67, 8'h75, 8'h65, 8'h73, 8'h74, 8'h2d};
		bootp = udp + 8;
		ulen  = {frm[udp + 4], frm[udp + 5]};
		for (int k = 0; k < 9; k++) frm[hpos + k] = pfx[k];
		frm[bootp + 8] = 0;
		frm[bootp + 9] = 0;
		s = {frm[26], frm[27]} + {frm[28], frm[29]} + {frm[30], frm[31]} + {frm[32], frm[33]};
		s = s + 17 + ulen;
		for (i = 0; i + 1 < ulen; i += 2)
			if (i != 6) s = s + {frm[udp + i], frm[udp + i + 1]};
		if (i < ulen) s = s + {frm[udp + i], 8'h00};
		while (s[31:16] != 0) s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
		x = 16'hffff - s[15:0];
		{frm[bootp + 8], frm[bootp + 9]} = x;
		for (int k = 0; k < 9; k++) frm[hpos + k] = 8'h41;
	endtask

	initial begin
		int flen, udp, hpos, r;
		tx_idle = 26;
		rx_idle = 88;
		my_mac  = {8'h52, 8'h54, 8'h00, 8'($urandom), 16'($urandom)};
		for (int i = 0; i < 236; i++) body[i] = $urandom;
		repeat (7) @(negedge clk);
		arst_n = 1;

		send(CMD_LOAD, 2047, 8'hff, 0, 0);
		send(CMD_LOAD, 0, 8'h00, 12'hfff, 1);
		send(CMD_READ, 2047, 0, 0, 0);
		send(CMD_READ, 0, 8'hff, 12'hfff, 1);
		send(CMD_NOP, 11'h7ff, 8'hff, 12'hfff, 1);
		send(CMD_PROCESS, 0, 0, 0, 1);
		send(CMD_PROCESS, 0, 0, 13, 1);

		// Receive frame before any identity: only the hostname changes, and the
		// payload is tuned so the recomputed checksum comes out as zero.
		build_dhcp(1, flen, udp, hpos);
		frm[hpos - 1] = 8'd9;
		for (int i = hpos + 9; i < flen; i++) frm[i] = OPT_END;
		force_zero_sum(udp, hpos);
		run_frame(flen, flen, 0, udp);

		build_dhcp(1, flen, udp, hpos);
		run_frame(flen, flen, 1, udp);
		// A length beyond the store saturates; the clean frame keeps every
		// access inside the loaded bytes.
		build_dhcp(1, flen, udp, hpos);
		run_frame(flen, 4095, 0, udp);
		build_arp(flen);
		run_frame(42, 42, 1, 0);

		while (n_items < ITEMS) begin
			if ($urandom_range(19) == 0)
				for (int i = 0; i < 236; i++) body[i] = $urandom;
			r = $urandom_range(99);
			if (r < 60) begin
				build_dhcp($urandom_range(2) == 0, flen, udp, hpos);
				run_frame(flen, flen, $urandom_range(1), udp);
			end else if (r < 75) begin
				build_arp(flen);
				run_frame(flen, flen, $urandom_range(1), 0);
			end else if (r < 83) begin
				build_misc(flen);
				run_frame(flen, flen, $urandom_range(1), 0);
			end else if (r < 88) begin
				repeat ($urandom_range(1, 4)) begin
					udp = $urandom_range(2047);
					send(CMD_LOAD, udp, $urandom, $urandom, $urandom);
					known[udp] = 0;
				end
			end else if (r < 92) begin
				send(CMD_NOP, $urandom, $urandom, $urandom, $urandom);
			end else if (r < 94) begin
				build_dhcp(1, flen, udp, hpos);
				run_frame(flen, $urandom_range(2049, 4095), $urandom_range(1), udp);
			end else begin
				flen = $urandom_range(0, 13);
				run_frame(flen, flen, $urandom_range(1), 0);
			end
		end
		s_axis_tvalid <= 0;
		while (waiting != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (errors == 0 && waiting == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+src
src/dfma_pkg.sv
src/dfma_ram.sv
src/dfma_fnv.sv
src/dhcp_frame_mac_anonymizer.sv
src/dfma_check.sv
sim/dfma_checker.sv
sim/tb_top.sv
